[hdl/lpc_pkg.sv]
// Package for the line position centroid unit: widths, constants,
// configuration codes and the structs passed between the pipeline cells.
// No dependencies.
`timescale 1ns / 1ps

package lpc_pkg;

	localparam int unsigned LANES      = 5;
	localparam int unsigned LEVEL_W    = 16;
	localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd4095;

	// plain sum of five 16-bit levels
	localparam int unsigned SUM_W      = 19;
	// signed weighted sum, |W| <= 10 * 65535
	localparam int unsigned WSUM_W     = 21;
	localparam int unsigned MAG_W      = WSUM_W - 1;

	// quotient magnitude is at most 7 * 1024, so 13 bits are enough
	localparam int unsigned Q_W        = 13;
	localparam int unsigned POS_W      = Q_W + 1;
	localparam int unsigned SCALE_SH   = 10;
	localparam int unsigned DVD_SH     = Q_W - SCALE_SH;

	localparam int unsigned MIN_W      = 15;
	localparam logic [MIN_W-1:0] MIN_STRENGTH_RST = 15'd256;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = MIN_W;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 1'b1;

	typedef logic [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic             invert;
		logic [MIN_W-1:0] min_strength;
	} lpc_cfg_t;

	// one transaction in flight through the divider chain
	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [SUM_W-1:0] divisor;
		logic [SUM_W-1:0] rem;
		logic [Q_W-1:0]   dvd;
		logic [Q_W-1:0]   quo;
	} lpc_div_t;

endpackage

[hdl/line_position_centroid_unit.sv]
// Top level of the line position centroid unit: config registers, front stage,
// divider cell chain and output stage. Depends on lpc_pkg, lpc_front,
// lpc_div_cell and lpc_out.
`timescale 1ns / 1ps

//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | in_valid, in_ready, level_0..4, black_0..4 | in
//  result  | out_valid, out_ready, position             | out
//  config  | cfg_we, cfg_idx, cfg_wdata                 | in, write only
//
//  Registered stages: one front stage, one divider cell per quotient bit
//  (13 cells), one output register. One transaction enters per cycle unless
//  the chain is full and stalled. Every stage holds its own valid bit and
//  advances when the next stage is empty or moving, so a stalled result only
//  backs up the chain as far as it is full; bubbles are squeezed out.
//  Reset clears the valid bits and loads the config registers with their
//  defaults (no inversion, minimum strength 256).

module line_position_centroid_unit #(
	parameter lpc_pkg::level_t FULL_SCALE = lpc_pkg::FULL_SCALE
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [lpc_pkg::LEVEL_W-1:0]        level_0,
	input  logic [lpc_pkg::LEVEL_W-1:0]        level_1,
	input  logic [lpc_pkg::LEVEL_W-1:0]        level_2,
	input  logic [lpc_pkg::LEVEL_W-1:0]        level_3,
	input  logic [lpc_pkg::LEVEL_W-1:0]        level_4,
	input  logic                               black_0,
	input  logic                               black_1,
	input  logic                               black_2,
	input  logic                               black_3,
	input  logic                               black_4,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lpc_pkg::POS_W-1:0]   position
);

	lpc_pkg::lpc_cfg_t  cfg_q;
	lpc_pkg::level_t    level [lpc_pkg::LANES];
	logic [lpc_pkg::LANES-1:0] black;

	// chain[0] comes from the front stage, chain[Q_W] feeds the output stage
	lpc_pkg::lpc_div_t  chain_data  [lpc_pkg::Q_W+1];
	logic               chain_valid [lpc_pkg::Q_W+1];
	logic               chain_ready [lpc_pkg::Q_W+1];

	// Config registers: the user must have them written only while the unit is idle
	// (unenforced), so read directly by the front stage. Drop writes to unknown indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.invert       <= 1'b0;
			cfg_q.min_strength <= lpc_pkg::MIN_STRENGTH_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				lpc_pkg::CFG_INVERT: cfg_q.invert       <= cfg_wdata[0];
				lpc_pkg::CFG_MIN:    cfg_q.min_strength <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign level[0] = level_0;
	assign level[1] = level_1;
	assign level[2] = level_2;
	assign level[3] = level_3;
	assign level[4] = level_4;
	assign black    = {black_4, black_3, black_2, black_1, black_0};

	// Clamp, invert and sum; set up the divider operands.
	lpc_front #(
		.FULL_SCALE (FULL_SCALE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.level     (level),
		.black     (black),
		.out_valid (chain_valid[0]),
		.out_ready (chain_ready[0]),
		.out_data  (chain_data[0])
	);

	// One quotient bit per cell, most significant first.
	for (genvar i = 0; i < lpc_pkg::Q_W; i++) begin : g_cell
		lpc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	// Sign, zero forcing and the result register.
	lpc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[lpc_pkg::Q_W]),
		.in_ready  (chain_ready[lpc_pkg::Q_W]),
		.in_data   (chain_data[lpc_pkg::Q_W]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position)
	);

endmodule

[hdl/lpc_front.sv]
// Front stage: clamp, optional inversion, weighted and plain sums, divider setup.
// Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_front #(
	parameter lpc_pkg::level_t FULL_SCALE = lpc_pkg::FULL_SCALE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lpc_pkg::lpc_cfg_t cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpc_pkg::level_t   level [lpc_pkg::LANES],
	input  logic [lpc_pkg::LANES-1:0] black,
	output logic              out_valid,
	input  logic              out_ready,
	output lpc_pkg::lpc_div_t out_data
);

	lpc_pkg::level_t                   lv [lpc_pkg::LANES];
	logic signed [lpc_pkg::WSUM_W-1:0] d_outer;
	logic signed [lpc_pkg::WSUM_W-1:0] d_inner;
	logic signed [lpc_pkg::WSUM_W-1:0] wsum;
	logic [lpc_pkg::MAG_W-1:0]         mag;
	logic [lpc_pkg::SUM_W-1:0]         plain;
	lpc_pkg::lpc_div_t                 nxt;
	logic                              valid_q;
	lpc_pkg::lpc_div_t                 data_q;

	always_comb begin
		for (int k = 0; k < lpc_pkg::LANES; k++) begin
			lv[k] = (level[k] > FULL_SCALE) ? FULL_SCALE : level[k];
			if (cfg.invert) begin
				lv[k] = FULL_SCALE - lv[k];
			end
		end
	end

	// weights -7, -3, 0, 3, 7: W = 7 * (l4 - l0) + 3 * (l3 - l1)
	assign d_outer = $signed({5'b0, lv[4]}) - $signed({5'b0, lv[0]});
	assign d_inner = $signed({5'b0, lv[3]}) - $signed({5'b0, lv[1]});
	assign wsum    = (d_outer <<< 3) - d_outer + (d_inner <<< 1) + d_inner;
	assign mag     = wsum[lpc_pkg::WSUM_W-1] ? lpc_pkg::MAG_W'(-wsum)
		: lpc_pkg::MAG_W'(wsum);

	assign plain = {3'b0, lv[0]} + {3'b0, lv[1]} + {3'b0, lv[2]}
		+ {3'b0, lv[3]} + {3'b0, lv[4]};

	always_comb begin
		nxt.neg     = wsum[lpc_pkg::WSUM_W-1];
		nxt.zero    = (~|black) || (plain < {4'b0, cfg.min_strength}) || (plain == '0);
		nxt.divisor = plain;
		// dividend is |W| * 1024; its top part is already below the divisor
		nxt.rem     = lpc_pkg::SUM_W'(mag >> lpc_pkg::DVD_SH);
		nxt.dvd     = {mag[lpc_pkg::DVD_SH-1:0], {lpc_pkg::SCALE_SH{1'b0}}};
		nxt.quo     = '0;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[hdl/lpc_div_cell.sv]
// One restoring-division cell: resolve one quotient bit, hand on to the next cell.
// Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lpc_pkg::lpc_div_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output lpc_pkg::lpc_div_t out_data
);

	logic [lpc_pkg::SUM_W:0] trial;
	logic [lpc_pkg::SUM_W:0] diff;
	logic                    ge;
	lpc_pkg::lpc_div_t       nxt;
	logic                    valid_q;
	lpc_pkg::lpc_div_t       data_q;

	// remainder stays below the divisor, so trial stays below twice the divisor
	assign trial = {in_data.rem, in_data.dvd[lpc_pkg::Q_W-1]};
	assign diff  = trial - {1'b0, in_data.divisor};
	assign ge    = trial >= {1'b0, in_data.divisor};

	always_comb begin
		nxt     = in_data;
		nxt.rem = ge ? diff[lpc_pkg::SUM_W-1:0] : trial[lpc_pkg::SUM_W-1:0];
		nxt.dvd = {in_data.dvd[lpc_pkg::Q_W-2:0], 1'b0};
		nxt.quo = {in_data.quo[lpc_pkg::Q_W-2:0], ge};
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

[hdl/lpc_out.sv]
// Output stage: apply sign, force zero when there is no line, hold the result.
// Depends on lpc_pkg.
`timescale 1ns / 1ps

module lpc_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  lpc_pkg::lpc_div_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [lpc_pkg::POS_W-1:0]  position
);

	logic [lpc_pkg::POS_W-1:0] mag;
	logic [lpc_pkg::POS_W-1:0] nxt;
	logic                      valid_q;
	logic [lpc_pkg::POS_W-1:0] pos_q;

	assign mag = {1'b0, in_data.quo};
	assign nxt = in_data.zero ? '0 : (in_data.neg ? (~mag + 1'b1) : mag);

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pos_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign position  = $signed(pos_q);

endmodule

[dv/tb.sv]
// Testbench for line_position_centroid_unit: a directed table, then random frames
// under changing settings and idle patterns, checked against an in-bench predictor.
// Depends on lpc_pkg and line_position_centroid_unit.
`timescale 1ns / 1ps

module tb;

	// cycles with no transaction on either side before the watchdog gives up
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 210;
	localparam int RAND_MIN = -1;

	localparam longint LANE_WEIGHT [lpc_pkg::LANES] = '{-7, -3, 0, 3, 7};
	localparam longint POS_SCALE = 1024;

	// settings per random phase; RAND_MIN picks a random threshold
	localparam bit PHASE_INV [PHASES] = '{0, 1, 0, 1, 0, 1, 1, 0};
	localparam int PHASE_MIN [PHASES] = '{256, 0, 20475, 32767, RAND_MIN, RAND_MIN, 0, 256};
	// idle percentages per mode: none, sender idle, receiver stall, both
	localparam int SEND_PCT [4] = '{0, 76, 0, 25};
	localparam int STALL_PCT [4] = '{0, 0, 76, 25};

	typedef struct packed {
		logic [lpc_pkg::LANES-1:0][lpc_pkg::LEVEL_W-1:0] lvl;
		logic [lpc_pkg::LANES-1:0]                       blk;
	} frame_t;

	typedef struct {
		bit                               inv;
		logic [lpc_pkg::MIN_W-1:0]        min_s;
		frame_t                           f;
		bit                               known;
		logic signed [lpc_pkg::POS_W-1:0] pos;
	} row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_idx = lpc_pkg::CFG_INVERT;
	logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic [lpc_pkg::LEVEL_W-1:0]       level_0 = '0;
	logic [lpc_pkg::LEVEL_W-1:0]       level_1 = '0;
	logic [lpc_pkg::LEVEL_W-1:0]       level_2 = '0;
	logic [lpc_pkg::LEVEL_W-1:0]       level_3 = '0;
	logic [lpc_pkg::LEVEL_W-1:0]       level_4 = '0;
	logic                              black_0 = 1'b0;
	logic                              black_1 = 1'b0;
	logic                              black_2 = 1'b0;
	logic                              black_3 = 1'b0;
	logic                              black_4 = 1'b0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [lpc_pkg::POS_W-1:0]  position;

	// positions still owed by the block, oldest first
	logic signed [lpc_pkg::POS_W-1:0] position_q [$];
	row_t directed_rows [$];

	bit                        cur_invert = 1'b0;
	logic [lpc_pkg::MIN_W-1:0] cur_min = lpc_pkg::MIN_STRENGTH_RST;
	int                        send_idle_pct = 0;
	int                        stall_pct = 0;
	int                        mismatch_cnt = 0;
	int                        quiet_cycles = 0;

	line_position_centroid_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.level_0   (level_0),
		.level_1   (level_1),
		.level_2   (level_2),
		.level_3   (level_3),
		.level_4   (level_4),
		.black_0   (black_0),
		.black_1   (black_1),
		.black_2   (black_2),
		.black_3   (black_3),
		.black_4   (black_4),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.position  (position)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Weighted centroid of one frame: clamp each level to full scale, flip it when
	// the polarity is inverted, then divide 1024 times the weighted sum by the plain
	// sum, truncating toward zero. No black flag or a weak plain sum gives zero.
	function automatic logic signed [lpc_pkg::POS_W-1:0] centroid_position(frame_t f,
			bit inv, logic [lpc_pkg::MIN_W-1:0] min_s);
		longint weighted;
		longint plain;
		longint v;
		longint q;
		weighted = 0;
		plain = 0;
		q = 0;
		for (int k = 0; k < lpc_pkg::LANES; k++) begin
			v = longint'(f.lvl[k]);
			if (v > longint'(lpc_pkg::FULL_SCALE))
				v = longint'(lpc_pkg::FULL_SCALE);
			if (inv)
				v = longint'(lpc_pkg::FULL_SCALE) - v;
			weighted += v * LANE_WEIGHT[k] * POS_SCALE;
			plain += v;
		end
		if (|f.blk && plain >= longint'(min_s) && plain != 0)
			q = weighted / plain;
		return q[lpc_pkg::POS_W-1:0];
	endfunction

	function automatic void add_row(bit inv, int min_s, int l0, int l1, int l2, int l3,
			int l4, logic [lpc_pkg::LANES-1:0] blk, bit known, int pos);
		row_t r;
		r.inv = inv;
		r.min_s = lpc_pkg::MIN_W'(min_s);
		r.f.lvl = {lpc_pkg::LEVEL_W'(l4), lpc_pkg::LEVEL_W'(l3), lpc_pkg::LEVEL_W'(l2),
			lpc_pkg::LEVEL_W'(l1), lpc_pkg::LEVEL_W'(l0)};
		r.f.blk = blk;
		r.known = known;
		r.pos = lpc_pkg::POS_W'(pos);
		directed_rows.push_back(r);
	endfunction

	// Mostly in-range levels with random content; some weak, some over full scale,
	// some raw 16-bit patterns so every level bit toggles.
	function automatic frame_t random_frame();
		frame_t f;
		int pick;
		for (int k = 0; k < lpc_pkg::LANES; k++) begin
			pick = $urandom_range(9);
			case (pick)
				6: f.lvl[k] = lpc_pkg::LEVEL_W'($urandom_range(300));
				7: f.lvl[k] = lpc_pkg::LEVEL_W'($urandom);
				8: f.lvl[k] = ($urandom_range(1)) ? lpc_pkg::FULL_SCALE
					: lpc_pkg::FULL_SCALE + 1'b1;
				9: f.lvl[k] = lpc_pkg::LEVEL_W'($urandom_range(65535, 4096));
				default: f.lvl[k] = lpc_pkg::LEVEL_W'($urandom_range(4095));
			endcase
		end
		f.blk = ($urandom_range(4) == 0) ? '0 : lpc_pkg::LANES'($urandom);
		return f;
	endfunction

	// Present one frame, hold it until accepted, log what it should produce, then
	// optionally drop valid for a random gap.
	task automatic push_frame(frame_t f, bit known, logic signed [lpc_pkg::POS_W-1:0] pos);
		logic signed [lpc_pkg::POS_W-1:0] want;
		in_valid <= 1'b1;
		level_0 <= f.lvl[0];
		level_1 <= f.lvl[1];
		level_2 <= f.lvl[2];
		level_3 <= f.lvl[3];
		level_4 <= f.lvl[4];
		black_0 <= f.blk[0];
		black_1 <= f.blk[1];
		black_2 <= f.blk[2];
		black_3 <= f.blk[3];
		black_4 <= f.blk[4];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		want = known ? pos : centroid_position(f, cur_invert, cur_min);
		position_q.push_back(want);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Stop sending and hold until every owed position has come out.
	task automatic settle();
		in_valid <= 1'b0;
		while (position_q.size() != 0)
			@(posedge clk);
	endtask

	// Write both registers on back-to-back cycles; the block must be idle.
	task automatic load_settings(bit inv, logic [lpc_pkg::MIN_W-1:0] min_s);
		cfg_we <= 1'b1;
		cfg_idx <= lpc_pkg::CFG_INVERT;
		cfg_wdata <= lpc_pkg::CFG_DATA_W'(inv);
		@(posedge clk);
		cfg_idx <= lpc_pkg::CFG_MIN;
		cfg_wdata <= min_s;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_invert = inv;
		cur_min = min_s;
	endtask

	// Result side: randomize ready each cycle and check every accepted position
	// against the oldest entry in the queue.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (position_q.size() == 0) begin
				$display("%0t: unexpected position, expected none actual %0d", $time,
					position);
				mismatch_cnt++;
			end else begin
				if (position !== position_q[0]) begin
					$display("%0t: position mismatch, expected %0d actual %0d", $time,
						position_q[0], position);
					mismatch_cnt++;
				end
				void'(position_q.pop_front());
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog expired with %0d positions owed", $time,
					position_q.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int min_s;
		int mode;

		// inv, min, level_0..level_4, black flags (bit k = sensor k), typed?, position
		add_row(0, 256, 0, 0, 0, 0, 0, 5'b00000, 1, 0);                 // all dark, no line
		add_row(0, 256, 4095, 0, 0, 0, 0, 5'b00001, 1, -7168);          // hard left
		add_row(0, 256, 0, 0, 0, 0, 4095, 5'b10000, 1, 7168);           // hard right
		add_row(0, 256, 65535, 0, 0, 0, 0, 5'b11111, 1, -7168);         // clamp over range
		add_row(0, 256, 65535, 65535, 65535, 65535, 65535, 5'b11111, 1, 0);
		add_row(0, 256, 0, 4095, 0, 0, 0, 5'b00010, 1, -3072);
		add_row(0, 256, 0, 0, 0, 4095, 0, 5'b01000, 1, 3072);
		add_row(0, 256, 0, 0, 4095, 0, 0, 5'b00100, 1, 0);
		add_row(0, 256, 0, 4096, 0, 0, 0, 5'b00010, 1, -3072);          // just above full scale
		add_row(0, 256, 0, 0, 0, 255, 0, 5'b01000, 1, 0);               // one short of threshold
		add_row(0, 256, 0, 0, 0, 256, 0, 5'b01000, 1, 3072);            // exactly at threshold
		add_row(0, 256, 4095, 0, 0, 0, 4095, 5'b00000, 1, 0);           // strong but no flag
		add_row(0, 256, 100, 0, 200, 0, 0, 5'b00001, 0, 0);             // truncate negative
		add_row(0, 256, 1000, 2000, 0, 3000, 4096, 5'b10100, 0, 0);
		add_row(0, 256, 16'hAAAA, 16'h5555, 16'h0AAA, 16'h0555, 16'h0FFF, 5'b01010, 0, 0);
		add_row(1, 256, 0, 0, 0, 0, 0, 5'b11111, 1, 0);                 // inverted, balanced
		add_row(1, 256, 4095, 4095, 4095, 4095, 0, 5'b00001, 1, 7168);
		add_row(1, 256, 65535, 65535, 65535, 65535, 65535, 5'b11111, 1, 0);
		add_row(1, 256, 300, 4000, 17, 2500, 65000, 5'b00110, 0, 0);
		add_row(0, 0, 0, 0, 0, 0, 0, 5'b11111, 1, 0);                   // zero sum, no divide
		add_row(0, 0, 1, 0, 0, 0, 0, 5'b00001, 1, -7168);
		add_row(0, 20475, 4095, 4095, 4095, 4095, 4095, 5'b11111, 1, 0);
		add_row(0, 20475, 4095, 4095, 4095, 4095, 4094, 5'b10000, 1, 0); // sum one short
		add_row(0, 32767, 65535, 65535, 65535, 65535, 65535, 5'b11111, 1, 0);
		add_row(0, 256, 1234, 0, 50, 77, 9, 5'b11011, 0, 0);

		// hold reset, then release it on a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: full rate, reload settings only when a row asks for new ones
		foreach (directed_rows[i]) begin
			if (directed_rows[i].inv != cur_invert || directed_rows[i].min_s != cur_min) begin
				settle();
				load_settings(directed_rows[i].inv, directed_rows[i].min_s);
			end
			push_frame(directed_rows[i].f, directed_rows[i].known, directed_rows[i].pos);
		end

		// random part: each phase drains, reloads settings and switches idle pattern
		for (int p = 0; p < PHASES; p++) begin
			settle();
			min_s = (PHASE_MIN[p] == RAND_MIN) ? $urandom_range(2000) : PHASE_MIN[p];
			load_settings(PHASE_INV[p], lpc_pkg::MIN_W'(min_s));
			mode = p % 4;
			send_idle_pct = SEND_PCT[mode];
			stall_pct = STALL_PCT[mode];
			for (int n = 0; n < PHASE_ITEMS; n++)
				push_frame(random_frame(), 1'b0, '0);
		end

		// wait out the pipeline, then give late extras a chance to show up
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
